@@ rtl/cnsrch_pkg.sv @@
// shared constants, register indexes and crc helper for the crc32 nonce search
package cnsrch_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ZCOUNT_W = 6;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_HEIGHT   = 2'd0,
        REG_PREVIOUS_HASH  = 2'd1,
        REG_MINER_ID       = 2'd2,
        REG_REQUIRED_ZEROS = 2'd3
    } t_cfg_idx;

    // fold one little-endian word into a reflected crc, one bit per step
    function automatic logic [WORD_W-1:0] f_crc_word(
        input logic [WORD_W-1:0] crc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] c;
        c = crc ^ word;
        for (int i = 0; i < WORD_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/cnsrch_crc.sv @@
// crc-32 over height, timestamp, previous hash, nonce and miner id as one xor tree
module cnsrch_crc import cnsrch_pkg::*; (
    input  logic [WORD_W-1:0] i_height,
    input  logic [WORD_W-1:0] i_timestamp,
    input  logic [WORD_W-1:0] i_parent_hash,
    input  logic [WORD_W-1:0] i_nonce,
    input  logic [WORD_W-1:0] i_miner_id,
    output logic [WORD_W-1:0] o_hash
);

    logic [WORD_W-1:0] c0;
    logic [WORD_W-1:0] c1;
    logic [WORD_W-1:0] c2;
    logic [WORD_W-1:0] c3;
    logic [WORD_W-1:0] c4;

    always_comb begin
        c0     = f_crc_word(CRC_INIT, i_height);
        c1     = f_crc_word(c0, i_timestamp);
        c2     = f_crc_word(c1, i_parent_hash);
        c3     = f_crc_word(c2, i_nonce);
        c4     = f_crc_word(c3, i_miner_id);
        o_hash = c4 ^ CRC_XOUT;
    end

endmodule

@@ rtl/cnsrch_zchk.sv @@
// leading zero check of the hash against the required difficulty
module cnsrch_zchk import cnsrch_pkg::*; (
    input  logic [WORD_W-1:0]   i_hash,
    input  logic [ZCOUNT_W-1:0] i_required,
    output logic                o_found
);

    logic [WORD_W-1:0] top_mask;
    logic              in_range;

    always_comb begin
        // top bits that must be zero; a shift of 32 leaves an all-ones mask
        top_mask = ~(CRC_INIT >> i_required);
        in_range = (i_required <= ZCOUNT_W'(WORD_W));
        o_found  = in_range && ((i_hash & top_mask) == '0);
    end

endmodule

@@ rtl/crc32_nonce_search_trial_top.sv @@
// top level of the crc32 nonce search trial engine
// an accepted input beat passes through the input register, then the result register, to its result beat
// throughput: one trial per cycle while i_stall does not hold the output, set by the combinational crc xor tree
// a waiting result lets one more beat into the input register, then stalls the input
// reset (synchronous, active low) clears the nonce counter, all config
// registers and both valid flags
module crc32_nonce_search_trial_top import cnsrch_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_W-1:0]    i_timestamp,
    input  logic                 i_restart,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_W-1:0]    o_hash,
    output logic [WORD_W-1:0]    o_trial_nonce,
    output logic                 o_found
);

    logic [WORD_W-1:0]   r_height;
    logic [WORD_W-1:0]   r_parent_hash;
    logic [WORD_W-1:0]   r_miner_id;
    logic [ZCOUNT_W-1:0] r_required;
    logic [WORD_W-1:0]   r_nonce;
    logic [WORD_W-1:0]   n_nonce;

    logic                r_s1_valid;
    logic [WORD_W-1:0]   r_s1_timestamp;
    logic [WORD_W-1:0]   r_s1_nonce;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_hash;
    logic [WORD_W-1:0]   r_out_nonce;
    logic                r_out_found;

    logic                out_load;
    logic                in_take;
    logic [WORD_W-1:0]   s1_hash;
    logic                s1_found;

    assign out_load = !r_out_valid || !i_stall;
    assign in_take  = i_valid && (!r_s1_valid || out_load);
    assign o_stall  = r_s1_valid && !out_load;
    assign n_nonce  = (i_restart ? '0 : r_nonce) + WORD_W'(1);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height      <= '0;
            r_parent_hash <= '0;
            r_miner_id    <= '0;
            r_required    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_BLOCK_HEIGHT:   r_height      <= i_cfg_data;
                REG_PREVIOUS_HASH:  r_parent_hash <= i_cfg_data;
                REG_MINER_ID:       r_miner_id    <= i_cfg_data;
                REG_REQUIRED_ZEROS: r_required    <= i_cfg_data[ZCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // nonce counter and input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_nonce <= n_nonce;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_timestamp <= i_timestamp;
            r_s1_nonce     <= n_nonce;
        end
    end

    cnsrch_crc u_crc (
        .i_height      (r_height),
        .i_timestamp   (r_s1_timestamp),
        .i_parent_hash (r_parent_hash),
        .i_nonce       (r_s1_nonce),
        .i_miner_id    (r_miner_id),
        .o_hash        (s1_hash)
    );

    cnsrch_zchk u_zchk (
        .i_hash     (s1_hash),
        .i_required (r_required),
        .o_found    (s1_found)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_hash  <= s1_hash;
            r_out_nonce <= r_s1_nonce;
            r_out_found <= s1_found;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hash        = r_out_hash;
    assign o_trial_nonce = r_out_nonce;
    assign o_found       = r_out_found;

    a_restart_nonce_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_restart) |=> (r_s1_nonce == WORD_W'(1)))
        else $error("restart beat did not use nonce one");

    a_nonce_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_restart) |=> (r_s1_nonce == $past(r_nonce) + WORD_W'(1)))
        else $error("nonce did not advance by one");

    a_zero_difficulty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_required == '0)) |-> o_found)
        else $error("zero difficulty beat not flagged found");

    a_zero_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hash == '0) && (r_required <= ZCOUNT_W'(WORD_W))) |-> o_found)
        else $error("zero hash beat not flagged found");

endmodule
